// ===== sv/asfu_pkg.sv =====
package asfu_pkg;

  // alu operation codes
  typedef enum logic [3:0] {
    OP_AND     = 4'd0,
    OP_XOR     = 4'd1,
    OP_SUB     = 4'd2,
    OP_RSUB    = 4'd3,
    OP_ADD     = 4'd4,
    OP_ADC     = 4'd5,
    OP_SBC     = 4'd6,
    OP_RSBC    = 4'd7,
    OP_CMP_AND = 4'd8,
    OP_CMP_XOR = 4'd9,
    OP_CMP_SUB = 4'd10,
    OP_CMP_ADD = 4'd11,
    OP_OR      = 4'd12,
    OP_CMOV    = 4'd13,
    OP_ANDNOT  = 4'd14,
    OP_CMVN    = 4'd15
  } alu_op_t;

  // barrel shifter modes
  typedef enum logic [2:0] {
    SHIFT_LSL       = 3'd0,
    SHIFT_LSR       = 3'd1,
    SHIFT_ASR       = 3'd2,
    SHIFT_ROR       = 3'd3,
    SHIFT_ROT_IMM   = 3'd4,
    SHIFT_LSR_PLAIN = 3'd5,
    SHIFT_ASR_PLAIN = 3'd6,
    SHIFT_NONE      = 3'd7
  } shift_kind_t;

  // condition codes
  typedef enum logic [3:0] {
    COND_EQ = 4'd0,
    COND_NE = 4'd1,
    COND_CS = 4'd2,
    COND_CC = 4'd3,
    COND_MI = 4'd4,
    COND_PL = 4'd5,
    COND_VS = 4'd6,
    COND_VC = 4'd7,
    COND_HI = 4'd8,
    COND_LS = 4'd9,
    COND_GE = 4'd10,
    COND_LT = 4'd11,
    COND_GT = 4'd12,
    COND_LE = 4'd13,
    COND_AL = 4'd14,
    COND_NV = 4'd15
  } cond_t;

  // nzcv, n in the top bit
  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
  } flags_t;

  localparam int AMOUNT_BITS = 5;

  // shifter control
  typedef struct packed {
    shift_kind_t            kind;
    logic [AMOUNT_BITS-1:0] amount;
    logic                   carry_in;
  } shift_ctl_t;

endpackage

// ===== sv/asfu_ifs.sv =====
interface asfu_req_if #(parameter int WORD_BITS = 32) ();
  logic                 valid;
  logic                 ready;
  logic [3:0]           operation;
  logic [WORD_BITS-1:0] first_operand;
  logic [WORD_BITS-1:0] second_operand;
  logic [2:0]           shift_kind;
  logic [4:0]           shift_amount;
  logic                 set_flags;
  logic [3:0]           condition;
  logic [4:0]           dest_index;

  modport source (
    output valid, operation, first_operand, second_operand, shift_kind,
           shift_amount, set_flags, condition, dest_index,
    input  ready
  );
  modport sink (
    input  valid, operation, first_operand, second_operand, shift_kind,
           shift_amount, set_flags, condition, dest_index,
    output ready
  );
endinterface

interface asfu_rsp_if #(parameter int WORD_BITS = 32) ();
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] result;
  logic                 write_enable;
  logic [4:0]           dest_index_out;
  logic [3:0]           flags_out;

  modport source (
    output valid, result, write_enable, dest_index_out, flags_out,
    input  ready
  );
  modport sink (
    input  valid, result, write_enable, dest_index_out, flags_out,
    output ready
  );
endinterface

// ===== sv/alu_shifter_flags_unit.sv =====
// channel | modport             | moves                                        | handshake
// req     | asfu_req_if.sink    | operation, operands, shift, flags ctl, dest  | valid/ready
// rsp     | asfu_rsp_if.source  | result, write_enable, dest_index_out, flags  | valid/ready
//
// one request per cycle sustained while rsp is not stalled; an accepted request passes
// through the input register and then the result register before it can leave on rsp
// the nzcv register closes a loop: it updates as a request leaves
// the input register, so the next request there sees the new flags
// rst (synchronous) clears both valid bits and nzcv
// a stalled rsp holds its result; req stays ready while the input register can move
module alu_shifter_flags_unit import asfu_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  asfu_req_if.sink   req,
  asfu_rsp_if.source rsp
);

  // input register
  logic                   s1_valid;
  logic [3:0]             s1_operation;
  logic [WORD_BITS-1:0]   s1_first_operand;
  logic [WORD_BITS-1:0]   s1_second_operand;
  logic [2:0]             s1_shift_kind;
  logic [AMOUNT_BITS-1:0] s1_shift_amount;
  logic                   s1_set_flags;
  logic [3:0]             s1_condition;
  logic [4:0]             s1_dest_index;

  // result register
  logic                   out_valid;
  logic [WORD_BITS-1:0]   out_result;
  logic                   out_write_enable;
  logic [4:0]             out_dest_index;
  flags_t                 out_flags;

  // architectural flags
  flags_t                 flags;
  flags_t                 flags_next;

  logic                   out_free;
  logic                   s1_move;

  shift_ctl_t             shift_ctl;
  logic [WORD_BITS-1:0]   shifted;
  logic                   shift_carry;

  alu_op_t                op;
  logic [WORD_BITS-1:0]   a_opnd;
  logic [WORD_BITS-1:0]   b_opnd;
  logic [WORD_BITS-1:0]   logic_res;
  logic [WORD_BITS-1:0]   alu_res;
  logic [WORD_BITS:0]     sum;
  logic                   cin;
  logic                   arith;
  logic                   is_cmp;
  logic                   is_cmov;
  logic                   cond_ok;
  logic                   skip;
  logic                   update_flags;
  logic                   write_next;
  logic [WORD_BITS-1:0]   result_next;
  flags_t                 alu_flags;

  function automatic logic cond_holds(input cond_t cond, input flags_t f);
    logic ok;
    begin
      case (cond)
        COND_EQ: ok = f.z;
        COND_NE: ok = !f.z;
        COND_CS: ok = f.c;
        COND_CC: ok = !f.c;
        COND_MI: ok = f.n;
        COND_PL: ok = !f.n;
        COND_VS: ok = f.v;
        COND_VC: ok = !f.v;
        COND_HI: ok = f.c && !f.z;
        COND_LS: ok = !f.c || f.z;
        COND_GE: ok = (f.n == f.v);
        COND_LT: ok = (f.n != f.v);
        COND_GT: ok = (f.n == f.v) && !f.z;
        COND_LE: ok = f.z || (f.n != f.v);
        COND_AL: ok = 1'b1;
        COND_NV: ok = 1'b0;
        default: ok = 1'b0;
      endcase
      return ok;
    end
  endfunction

  // handshake: result register frees when empty or being taken
  assign out_free  = !out_valid || rsp.ready;
  assign s1_move   = s1_valid && out_free;
  assign req.ready = !s1_valid || out_free;

  assign rsp.valid          = out_valid;
  assign rsp.result         = out_result;
  assign rsp.write_enable   = out_write_enable;
  assign rsp.dest_index_out = out_dest_index;
  assign rsp.flags_out      = out_flags;

  // barrel shifter on the second operand
  assign shift_ctl.kind     = shift_kind_t'(s1_shift_kind);
  assign shift_ctl.amount   = s1_shift_amount;
  assign shift_ctl.carry_in = flags.c;

  asfu_shifter #(
    .WORD_BITS (WORD_BITS)
  ) u_shifter (
    .ctl     (shift_ctl),
    .value   (s1_second_operand),
    .shifted (shifted),
    .carry   (shift_carry)
  );

  // alu and flag logic
  always_comb begin
    op        = alu_op_t'(s1_operation);
    a_opnd    = s1_first_operand;
    b_opnd    = shifted;
    cin       = 1'b0;
    arith     = 1'b0;
    logic_res = '0;
    case (op)
      OP_AND, OP_CMP_AND: logic_res = s1_first_operand & shifted;
      OP_XOR, OP_CMP_XOR: logic_res = s1_first_operand ^ shifted;
      OP_SUB, OP_CMP_SUB: begin
        b_opnd = ~shifted;
        cin    = 1'b1;
        arith  = 1'b1;
      end
      OP_RSUB: begin
        a_opnd = shifted;
        b_opnd = ~s1_first_operand;
        cin    = 1'b1;
        arith  = 1'b1;
      end
      OP_ADD, OP_CMP_ADD: arith = 1'b1;
      OP_ADC: begin
        cin   = flags.c;
        arith = 1'b1;
      end
      OP_SBC: begin
        b_opnd = ~shifted;
        cin    = flags.c;
        arith  = 1'b1;
      end
      OP_RSBC: begin
        a_opnd = shifted;
        b_opnd = ~s1_first_operand;
        cin    = flags.c;
        arith  = 1'b1;
      end
      OP_OR:     logic_res = s1_first_operand | shifted;
      OP_CMOV:   logic_res = shifted;
      OP_ANDNOT: logic_res = s1_first_operand & ~shifted;
      OP_CMVN:   logic_res = ~shifted;
      default:   logic_res = '0;
    endcase

    sum     = {1'b0, a_opnd} + {1'b0, b_opnd} + {{WORD_BITS{1'b0}}, cin};
    alu_res = arith ? sum[WORD_BITS-1:0] : logic_res;

    is_cmp  = (op == OP_CMP_AND) || (op == OP_CMP_XOR) ||
              (op == OP_CMP_SUB) || (op == OP_CMP_ADD);
    is_cmov = (op == OP_CMOV) || (op == OP_CMVN);
    cond_ok = cond_holds(cond_t'(s1_condition), flags);
    // failed conditional move: no write, no flag change, zero result
    skip    = is_cmov && !cond_ok;

    alu_flags.n = alu_res[WORD_BITS-1];
    alu_flags.z = (alu_res == '0);
    alu_flags.c = arith ? sum[WORD_BITS] : shift_carry;
    alu_flags.v = arith ? ((a_opnd[WORD_BITS-1] == b_opnd[WORD_BITS-1]) &&
                           (a_opnd[WORD_BITS-1] != alu_res[WORD_BITS-1]))
                        : flags.v;

    update_flags = !skip && (s1_set_flags || is_cmp);
    flags_next   = update_flags ? alu_flags : flags;
    write_next   = !is_cmp && !skip;
    result_next  = skip ? '0 : alu_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      flags     <= '0;
    end else begin
      if (req.ready) begin
        s1_valid <= req.valid;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
      if (s1_move) begin
        flags <= flags_next;
      end
    end

    if (req.valid && req.ready) begin
      s1_operation      <= req.operation;
      s1_first_operand  <= req.first_operand;
      s1_second_operand <= req.second_operand;
      s1_shift_kind     <= req.shift_kind;
      s1_shift_amount   <= req.shift_amount;
      s1_set_flags      <= req.set_flags;
      s1_condition      <= req.condition;
      s1_dest_index     <= req.dest_index;
    end

    if (s1_move) begin
      out_result       <= result_next;
      out_write_enable <= write_next;
      out_dest_index   <= s1_dest_index;
      out_flags        <= flags_next;
    end
  end

endmodule

// ===== sv/asfu_shifter.sv =====
module asfu_shifter import asfu_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  shift_ctl_t           ctl,
  input  logic [WORD_BITS-1:0] value,
  output logic [WORD_BITS-1:0] shifted,
  output logic                 carry
);

  localparam int SHW = ($clog2(WORD_BITS + 1) > AMOUNT_BITS) ?
                       $clog2(WORD_BITS + 1) : AMOUNT_BITS;
  localparam logic [SHW-1:0] W_AMT = SHW'(WORD_BITS);
  // enough subtractions to fold a 5 bit amount below the word width
  localparam int FOLD_STEPS = ((1 << AMOUNT_BITS) + WORD_BITS - 1) / WORD_BITS;

  logic [SHW-1:0]               amt_ext;
  logic [SHW-1:0]               amt_full;
  logic [SHW-1:0]               amt_sat;
  logic [SHW-1:0]               rot_amt;
  logic [2*WORD_BITS-1:0]       lsl_wide;
  logic [2*WORD_BITS-1:0]       lsr_wide;
  logic signed [2*WORD_BITS-1:0] asr_wide;
  logic [2*WORD_BITS-1:0]       rot_wide;
  logic signed [WORD_BITS-1:0]  asr_plain;

  always_comb begin
    amt_ext  = SHW'(ctl.amount);
    // zero amount on lsr and asr means a full-width shift
    amt_full = (amt_ext == '0) ? W_AMT : amt_ext;
    amt_sat  = (amt_full > W_AMT) ? W_AMT : amt_full;

    rot_amt = amt_ext;
    for (int k = 0; k < FOLD_STEPS; k++) begin
      if (rot_amt >= W_AMT) begin
        rot_amt = rot_amt - W_AMT;
      end
    end

    lsl_wide  = {{WORD_BITS{1'b0}}, value} << amt_ext;
    lsr_wide  = {value, {WORD_BITS{1'b0}}} >> amt_full;
    asr_wide  = $signed({value, {WORD_BITS{1'b0}}}) >>> amt_sat;
    rot_wide  = {value, value} >> rot_amt;
    asr_plain = $signed(value) >>> amt_ext;

    shifted = value;
    carry   = 1'b0;
    case (ctl.kind)
      SHIFT_LSL: begin
        shifted = lsl_wide[WORD_BITS-1:0];
        carry   = lsl_wide[WORD_BITS];
      end
      SHIFT_LSR: begin
        shifted = lsr_wide[2*WORD_BITS-1:WORD_BITS];
        carry   = lsr_wide[WORD_BITS-1];
      end
      SHIFT_ASR: begin
        shifted = asr_wide[2*WORD_BITS-1:WORD_BITS];
        carry   = asr_wide[WORD_BITS-1];
      end
      SHIFT_ROR: begin
        if (amt_ext == '0) begin
          // rrx
          shifted = {ctl.carry_in, value[WORD_BITS-1:1]};
          carry   = value[0];
        end else begin
          shifted = rot_wide[WORD_BITS-1:0];
          carry   = rot_wide[WORD_BITS-1];
        end
      end
      SHIFT_ROT_IMM: begin
        if (amt_ext != '0) begin
          shifted = rot_wide[WORD_BITS-1:0];
          carry   = rot_wide[WORD_BITS-1];
        end
      end
      SHIFT_LSR_PLAIN: shifted = value >> amt_ext;
      SHIFT_ASR_PLAIN: shifted = asr_plain;
      SHIFT_NONE:      shifted = value;
      default:         shifted = value;
    endcase
  end

endmodule

// ===== sv/asfu_checker.sv =====
module asfu_checker #(
  parameter int WORD_BITS = 32
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [WORD_BITS-1:0] out_result,
  input logic                 out_write_enable,
  input logic [4:0]           out_dest_index,
  input logic [3:0]           out_flags
);

  // a stalled result stays offered
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_result) && $stable(out_write_enable) &&
                                $stable(out_dest_index) && $stable(out_flags))
    else $error("result payload changed while stalled");

  // an empty result register means the input side can move
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("request side blocked with empty result register");

  // an accepted request is followed by a valid result once it could have passed both registers
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> ##1 out_valid)
    else $error("accepted request produced no result in time");

endmodule

bind alu_shifter_flags_unit asfu_checker #(
  .WORD_BITS (WORD_BITS)
) u_asfu_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (req.valid),
  .in_ready         (req.ready),
  .out_valid        (rsp.valid),
  .out_ready        (rsp.ready),
  .out_result       (rsp.result),
  .out_write_enable (rsp.write_enable),
  .out_dest_index   (rsp.dest_index_out),
  .out_flags        (rsp.flags_out)
);

// ===== verif/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import asfu_pkg::*;

  localparam int W           = 32;
  localparam int QUIET_LIMIT = 5000;  // cycles with no request or result accepted
  localparam int TAIL_CYCLES = 10;    // time for the input and result registers plus margin

  // one request as the sender sees it
  typedef struct {
    alu_op_t     op;
    logic [W-1:0] first;
    logic [W-1:0] second;
    shift_kind_t kind;
    logic [4:0]  amount;
    logic        set_flags;
    cond_t       cond;
    logic [4:0]  dest;
  } alu_req_t;

  // one predicted result
  typedef struct {
    logic [W-1:0] result;
    logic         write_enable;
    logic [4:0]   dest;
    flags_t       flags;
  } alu_resp_t;

  logic clk;
  logic rst;

  asfu_req_if #(.WORD_BITS(W)) req_ch ();
  asfu_rsp_if #(.WORD_BITS(W)) rsp_ch ();

  alu_shifter_flags_unit #(.WORD_BITS(W)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // predictor state: the nzcv register as the block should hold it
  flags_t    nzcv_model;
  alu_resp_t pending_results[$];

  // pacing knobs, percent of cycles
  int send_idle_pct;
  int recv_stall_pct;

  int quiet_cycles;
  int error_count;
  int n_requests;
  int n_results;
  int n_compares;
  int n_skipped_moves;

  logic [W-1:0] corner_values[5] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                                     32'h7FFF_FFFF, 32'h0000_0001};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // barrel shifter on the second operand; carry_now is the stored c for rrx
  function automatic void shift_second(input logic [W-1:0] v, input shift_kind_t kind,
                                       input logic [4:0] s, input logic carry_now,
                                       output logic [W-1:0] shifted, output logic carry_out);
    int k;
    k         = int'(s);
    shifted   = v;
    carry_out = 1'b0;
    case (kind)
      SHIFT_LSL: begin
        if (k != 0) begin
          carry_out = v[W-k];
          shifted   = v << k;
        end
      end
      SHIFT_LSR: begin
        // amount zero encodes a full-width shift
        if (k == 0) begin
          carry_out = v[W-1];
          shifted   = '0;
        end else begin
          carry_out = v[k-1];
          shifted   = v >> k;
        end
      end
      SHIFT_ASR: begin
        if (k == 0) begin
          carry_out = v[W-1];
          shifted   = {W{v[W-1]}};
        end else begin
          carry_out = v[k-1];
          shifted   = $signed(v) >>> k;
        end
      end
      SHIFT_ROR, SHIFT_ROT_IMM: begin
        if (k == 0) begin
          // rrx for the register form, plain pass for the immediate form
          if (kind == SHIFT_ROR) begin
            carry_out = v[0];
            shifted   = {carry_now, v[W-1:1]};
          end
        end else begin
          carry_out = v[k-1];
          shifted   = (v >> k) | (v << (W - k));
        end
      end
      SHIFT_LSR_PLAIN: shifted = v >> k;
      SHIFT_ASR_PLAIN: shifted = $signed(v) >>> k;
      default: ;
    endcase
  endfunction

  function automatic logic cond_met(input cond_t c, input flags_t f);
    case (c)
      COND_EQ: return f.z;
      COND_NE: return !f.z;
      COND_CS: return f.c;
      COND_CC: return !f.c;
      COND_MI: return f.n;
      COND_PL: return !f.n;
      COND_VS: return f.v;
      COND_VC: return !f.v;
      COND_HI: return f.c && !f.z;
      COND_LS: return !f.c || f.z;
      COND_GE: return f.n == f.v;
      COND_LT: return f.n != f.v;
      COND_GT: return (f.n == f.v) && !f.z;
      COND_LE: return f.z || (f.n != f.v);
      COND_AL: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // works out the result of one request and advances nzcv_model
  function automatic alu_resp_t predict_alu(input alu_req_t r);
    logic [W-1:0] b_sh, x, y, res;
    logic [W:0]   sum;
    logic         sc, cin, arith, setf, is_cmp, is_move;
    flags_t       f;
    alu_resp_t    e;
    x       = '0;
    y       = '0;
    res     = '0;
    sum     = '0;
    cin     = 1'b0;
    arith   = 1'b0;
    setf    = r.set_flags;
    is_cmp  = (r.op >= OP_CMP_AND) && (r.op <= OP_CMP_ADD);
    is_move = (r.op == OP_CMOV) || (r.op == OP_CMVN);
    e.dest  = r.dest;
    e.write_enable = 1'b1;
    if (is_cmp) begin
      e.write_enable = 1'b0;
      setf           = 1'b1;
    end else if (is_move) begin
      e.write_enable = cond_met(r.cond, nzcv_model);
    end
    // a move whose condition fails leaves everything alone
    if (is_move && !e.write_enable) begin
      e.result = '0;
      e.flags  = nzcv_model;
      return e;
    end
    shift_second(r.second, r.kind, r.amount, nzcv_model.c, b_sh, sc);
    case (r.op)
      OP_AND, OP_CMP_AND: res = r.first & b_sh;
      OP_XOR, OP_CMP_XOR: res = r.first ^ b_sh;
      OP_SUB, OP_CMP_SUB: begin
        x = r.first; y = ~b_sh; cin = 1'b1; arith = 1'b1;
      end
      OP_RSUB: begin
        x = b_sh; y = ~r.first; cin = 1'b1; arith = 1'b1;
      end
      OP_ADD, OP_CMP_ADD: begin
        x = r.first; y = b_sh; arith = 1'b1;
      end
      OP_ADC: begin
        x = r.first; y = b_sh; cin = nzcv_model.c; arith = 1'b1;
      end
      OP_SBC: begin
        x = r.first; y = ~b_sh; cin = nzcv_model.c; arith = 1'b1;
      end
      OP_RSBC: begin
        x = b_sh; y = ~r.first; cin = nzcv_model.c; arith = 1'b1;
      end
      OP_OR:     res = r.first | b_sh;
      OP_CMOV:   res = b_sh;
      OP_ANDNOT: res = r.first & ~b_sh;
      default:   res = ~b_sh;
    endcase
    if (arith) begin
      sum = {1'b0, x} + {1'b0, y} + {{W{1'b0}}, cin};
      res = sum[W-1:0];
    end
    f = nzcv_model;
    if (setf) begin
      f.n = res[W-1];
      f.z = (res == '0);
      if (arith) begin
        f.c = sum[W];
        f.v = (x[W-1] == y[W-1]) && (res[W-1] != x[W-1]);
      end else begin
        // logical kinds: carry from the shifter, overflow kept
        f.c = sc;
      end
      nzcv_model = f;
    end
    e.result = res;
    e.flags  = f;
    return e;
  endfunction

  task automatic report_mismatch(input string what, input logic [W-1:0] got,
                                 input logic [W-1:0] want);
    $display("mismatch on result %0d, %s: got %h, expected %h", n_results, what, got, want);
    error_count++;
  endtask

  // request and result monitor: predicts on accept, checks in order
  always @(posedge clk) begin
    alu_req_t  seen;
    alu_resp_t want;
    if (rst) begin
      nzcv_model   = '0;
      quiet_cycles = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        seen.op        = alu_op_t'(req_ch.operation);
        seen.first     = req_ch.first_operand;
        seen.second    = req_ch.second_operand;
        seen.kind      = shift_kind_t'(req_ch.shift_kind);
        seen.amount    = req_ch.shift_amount;
        seen.set_flags = req_ch.set_flags;
        seen.cond      = cond_t'(req_ch.condition);
        seen.dest      = req_ch.dest_index;
        if (seen.op >= OP_CMP_AND && seen.op <= OP_CMP_ADD)
          n_compares++;
        want = predict_alu(seen);
        if ((seen.op == OP_CMOV || seen.op == OP_CMVN) && !want.write_enable)
          n_skipped_moves++;
        pending_results.push_back(want);
        n_requests++;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with no request outstanding", rsp_ch.result, '0);
        end else begin
          want = pending_results.pop_front();
          if (rsp_ch.result !== want.result)
            report_mismatch("result", rsp_ch.result, want.result);
          if (rsp_ch.write_enable !== want.write_enable)
            report_mismatch("write_enable", W'(rsp_ch.write_enable),
                            W'(want.write_enable));
          if (rsp_ch.dest_index_out !== want.dest)
            report_mismatch("dest_index_out", W'(rsp_ch.dest_index_out), W'(want.dest));
          if (rsp_ch.flags_out !== want.flags)
            report_mismatch("flags_out", W'(rsp_ch.flags_out), W'(want.flags));
        end
        n_results++;
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  // result side back-pressure
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // hang detector
  initial begin
    @(posedge clk);
    wait (rst === 1'b0);
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("timeout: nothing accepted for %0d cycles", QUIET_LIMIT);
    $display("FAIL");
    $finish;
  end

  // sends one request; valid stays high on return so back-to-back costs no bubble
  task automatic send_op(input alu_op_t op, input logic [W-1:0] first,
                         input logic [W-1:0] second, input shift_kind_t kind,
                         input logic [4:0] amount, input logic set_flags,
                         input cond_t cond, input logic [4:0] dest);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid          <= 1'b1;
    req_ch.operation      <= op;
    req_ch.first_operand  <= first;
    req_ch.second_operand <= second;
    req_ch.shift_kind     <= kind;
    req_ch.shift_amount   <= amount;
    req_ch.set_flags      <= set_flags;
    req_ch.condition      <= cond;
    req_ch.dest_index     <= dest;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // sender holds off until every outstanding result is back
  task automatic wait_for_drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // all sixteen operations, every shift kind at amounts 0 and 31, corner operands
  task automatic test_every_operation();
    for (int i = 0; i < 16; i++) begin
      send_op(alu_op_t'(i), corner_values[i % 5], corner_values[(i + 2) % 5],
              shift_kind_t'(i % 8), (i < 8) ? 5'd0 : 5'd31, (i % 3) != 0,
              cond_t'(15 - i), 5'(2 * i + 1));
    end
  endtask

  // flag-dependent paths: skipped moves, never condition, rrx with carry set,
  // overflow, logical ops keeping v, and an update with flags not set
  task automatic test_conditional_moves();
    send_op(OP_CMP_SUB, 32'h0, 32'h1, SHIFT_NONE, 5'd0, 1'b0, COND_AL, 5'd0);
    send_op(OP_CMOV, 32'h1234_5678, 32'hDEAD_BEEF, SHIFT_NONE, 5'd0, 1'b1, COND_NV, 5'd1);
    send_op(OP_CMVN, 32'h0, 32'hA5A5_A5A5, SHIFT_LSL, 5'd4, 1'b1, COND_CS, 5'd2);
    send_op(OP_CMP_ADD, 32'hFFFF_FFFF, 32'h1, SHIFT_NONE, 5'd0, 1'b0, COND_AL, 5'd3);
    send_op(OP_CMOV, 32'h0, 32'h2, SHIFT_ROR, 5'd0, 1'b1, COND_EQ, 5'd4);
    send_op(OP_ADD, 32'h7FFF_FFFF, 32'h1, SHIFT_NONE, 5'd0, 1'b1, COND_AL, 5'd5);
    send_op(OP_CMVN, 32'h0, 32'hFFFF_0000, SHIFT_LSL, 5'd16, 1'b1, COND_VS, 5'd6);
    send_op(OP_SBC, 32'h8000_0000, 32'h1, SHIFT_ASR, 5'd1, 1'b0, COND_AL, 5'd31);
  endtask

  function automatic logic [W-1:0] random_operand();
    case ($urandom_range(9))
      0: return corner_values[0];
      1: return corner_values[1];
      2: return corner_values[2];
      3: return corner_values[3];
      4: return W'($urandom_range(15));
      default: return W'($urandom());
    endcase
  endfunction

  // random requests under one idling mix, then a full drain
  task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
    logic [4:0] amount;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(7))
        0:       amount = 5'd0;
        1:       amount = 5'd31;
        default: amount = 5'($urandom_range(31));
      endcase
      send_op(alu_op_t'($urandom_range(15)), random_operand(), random_operand(),
              shift_kind_t'($urandom_range(7)), amount, $urandom_range(3) != 0,
              cond_t'($urandom_range(15)), 5'($urandom_range(31)));
    end
    wait_for_drain();
  endtask

  initial begin
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    error_count     = 0;
    n_requests      = 0;
    n_results       = 0;
    n_compares      = 0;
    n_skipped_moves = 0;
    quiet_cycles    = 0;
    rst                   <= 1'b1;
    req_ch.valid          <= 1'b0;
    req_ch.operation      <= OP_AND;
    req_ch.first_operand  <= '0;
    req_ch.second_operand <= '0;
    req_ch.shift_kind     <= SHIFT_LSL;
    req_ch.shift_amount   <= '0;
    req_ch.set_flags      <= 1'b0;
    req_ch.condition      <= COND_AL;
    req_ch.dest_index     <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_every_operation();
    test_conditional_moves();
    wait_for_drain();

    // no idling, sender mostly idle, receiver mostly stalled, both lightly
    test_random_traffic(270, 0, 0);
    test_random_traffic(270, 81, 0);
    test_random_traffic(270, 0, 81);
    test_random_traffic(270, 29, 29);

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d requests (%0d compares, %0d skipped moves) under four idling mixes",
             n_requests, n_compares, n_skipped_moves);
    $display("%0d results checked field by field, %0d mismatches", n_results, error_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/asfu_pkg.sv
sv/asfu_ifs.sv
sv/asfu_shifter.sv
sv/alu_shifter_flags_unit.sv
sv/asfu_checker.sv
verif/tb.sv
